// ----- hdl/iptp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP address text parser package
// Shared character codes, status codes and the dotted-decimal step functions.
// ----------------------------------------------------------------------------
package iptp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  localparam logic [11:0] OCTET_MAX = 12'd255;
  localparam logic [4:0]  ADDR_BYTES = 5'd16;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MALFORMED   = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_t;

  // Dotted-decimal accumulator; byte 0 sits in bits 31:24.
  typedef struct packed {
    logic [7:0]  acc;
    logic        seen;
    logic [2:0]  cnt;
    logic [31:0] bytes;
  } v4_t;

  typedef struct packed {
    v4_t  st;
    logic ok;
  } v4_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = c[3:0];
    if (c >= CH_0 && c <= CH_9) begin
      h.val = c[3:0];
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // One dotted-decimal character.
  function automatic v4_res_t v4_feed(v4_t s, logic [7:0] c);
    v4_res_t    r;
    logic [11:0] n;
    logic [1:0]  idx;
    r.st = s;
    r.ok = 1'b0;
    n    = {4'd0, s.acc} * 12'd10 + {8'd0, c[3:0]};
    if (c >= CH_0 && c <= CH_9) begin
      if (!(s.seen && s.acc == 8'd0) && n <= OCTET_MAX) begin
        r.st.acc = n[7:0];
        if (!s.seen) begin
          if (s.cnt < 3'd4) begin
            r.st.cnt  = s.cnt + 3'd1;
            r.st.seen = 1'b1;
            r.ok      = 1'b1;
          end
        end else begin
          r.ok = 1'b1;
        end
        idx = r.st.cnt[1:0] - 2'd1;
        r.st.bytes[{~idx, 3'b000} +: 8] = n[7:0];
      end
    end else if (c == CH_DOT && s.seen) begin
      if (s.cnt != 3'd4) begin
        r.st.seen = 1'b0;
        r.st.acc  = 8'd0;
        r.ok      = 1'b1;
      end
    end
    return r;
  endfunction

  // Re-read the pending hex group as decimal digits, then take the dot.
  function automatic v4_res_t v4_dot_entry(logic [15:0] acc, logic [2:0] cnt,
                                           logic [31:0] bytes);
    v4_res_t    r;
    v4_t        t;
    logic       ok;
    logic [1:0] sel;
    logic [3:0] nib;
    t.acc   = 8'd0;
    t.seen  = 1'b0;
    t.cnt   = 3'd0;
    t.bytes = bytes;
    ok      = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < cnt) begin
        sel = cnt[1:0] - 2'd1 - 2'(k);
        nib = acc[{sel, 2'b00} +: 4];
        if (nib > 4'd9) ok = 1'b0;
        r = v4_feed(t, {4'h3, nib});
        if (!r.ok) ok = 1'b0;
        t = r.st;
      end
    end
    r    = v4_feed(t, CH_DOT);
    r.ok = r.ok && ok;
    return r;
  endfunction

endpackage

// ----- hdl/ip_address_text_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP address text parser
// Turns IPv4 dotted or IPv6 colon-hex text into a 128-bit binary address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one character per item in
//   in_ch; in_family is sampled with the first character of each string
//   (0 IPv4, 1 IPv6, other codes unsupported). A zero character ends the
//   string.
//   Result channel (out_valid/out_ready) carries one item per string:
//   out_status plus out_addr_high/out_addr_low. Characters other than the
//   terminator produce no result.
//   Throughput: one character per cycle while in_ready is high. Each
//   character updates the parse registers in the cycle it is accepted; the
//   terminator's result, including the gap expansion (a 16-byte shift mux),
//   is loaded into the output register as the terminator is accepted.
//   Latency: result valid on the cycle after the terminator is accepted.
//   Stall: while a result waits and out_ready is low, in_ready drops; the
//   held result and the parse state stay put.
//   Reset: clears all parse state and the output valid; the block starts at
//   the beginning of a string.
// ----------------------------------------------------------------------------
module ip_address_text_parser import iptp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic [1:0]  in_family,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,   // at string start
    PH_LEAD  = 2'd1,   // after a leading colon
    PH_BODY  = 2'd2
  } phase_t;

  localparam logic [127:0] ALL_ONES = '1;

  // Parse state
  phase_t       phase_r, phase_nxt;
  logic [1:0]   fam_r, fam_nxt;
  logic         err_r, err_nxt;
  logic [127:0] sh_r, sh_nxt;          // collected bytes, newest in the low end
  logic [4:0]   byte_cnt_r, byte_cnt_nxt;
  logic [4:0]   gap_pos_r, gap_pos_nxt;
  logic         gap_seen_r, gap_seen_nxt;
  logic [15:0]  hex_acc_r, hex_acc_nxt;
  logic [2:0]   hex_cnt_r, hex_cnt_nxt;
  logic         colon_grp_r, colon_grp_nxt;
  logic         tail_r, tail_nxt;
  v4_t          v4_r, v4_nxt;

  // Result register
  logic         out_valid_r, out_valid_nxt;
  status_t      out_status_r;
  logic [63:0]  out_addr_high_r, out_addr_low_r;

  logic         in_fire, is_term;
  logic [1:0]   eff_fam;
  logic         fam_ok;
  v4_res_t      v4_step, dot_step;
  hex_t         hexv;
  logic         feed_en, feed_ok;

  // Finish path
  status_t      fin_status;
  logic [127:0] fin_addr;
  logic         fok;
  logic [127:0] sh_f, gap_res;
  logic [4:0]   bc_f, gap_n;
  logic [4:0]   pre_n;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_term  = (in_ch == CH_NUL);
  assign eff_fam  = (phase_r == PH_START) ? in_family : fam_r;
  assign fam_ok   = (eff_fam == FAM_V4) || (eff_fam == FAM_V6);

  assign v4_step  = v4_feed(v4_r, in_ch);
  assign dot_step = v4_dot_entry(hex_acc_r, hex_cnt_r, v4_r.bytes);
  assign hexv     = hex_digit(in_ch);

  // Per-character update
  always_comb begin
    phase_nxt     = phase_r;
    fam_nxt       = fam_r;
    err_nxt       = err_r;
    sh_nxt        = sh_r;
    byte_cnt_nxt  = byte_cnt_r;
    gap_pos_nxt   = gap_pos_r;
    gap_seen_nxt  = gap_seen_r;
    hex_acc_nxt   = hex_acc_r;
    hex_cnt_nxt   = hex_cnt_r;
    colon_grp_nxt = colon_grp_r;
    tail_nxt      = tail_r;
    v4_nxt        = v4_r;
    feed_en       = 1'b0;
    feed_ok       = 1'b1;

    if (in_fire) begin
      if (is_term) begin
        // End of string: clear everything but the family.
        phase_nxt     = PH_START;
        fam_nxt       = eff_fam;
        err_nxt       = 1'b0;
        sh_nxt        = '0;
        byte_cnt_nxt  = '0;
        gap_pos_nxt   = '0;
        gap_seen_nxt  = 1'b0;
        hex_acc_nxt   = '0;
        hex_cnt_nxt   = '0;
        colon_grp_nxt = 1'b0;
        tail_nxt      = 1'b0;
        v4_nxt        = '0;
      end else begin
        priority if (phase_r == PH_START) begin
          fam_nxt = in_family;
          if (in_family == FAM_V6 && in_ch == CH_COLON) begin
            phase_nxt = PH_LEAD;
          end else begin
            phase_nxt = PH_BODY;
            feed_en   = fam_ok;
          end
        end else if (!err_r && fam_ok) begin
          if (phase_r == PH_LEAD) begin
            phase_nxt = PH_BODY;
            if (in_ch != CH_COLON) err_nxt = 1'b1;
            else                   feed_en = 1'b1;
          end else begin
            feed_en = 1'b1;
          end
        end else begin
          // drop characters after an error or for an unsupported family
        end

        if (feed_en) begin
          if (eff_fam == FAM_V4) begin
            v4_nxt  = v4_step.st;
            feed_ok = v4_step.ok;
          end else begin
            colon_grp_nxt = 1'b0;
            priority if (tail_r) begin
              v4_nxt  = v4_step.st;
              feed_ok = v4_step.ok;
            end else if (hexv.ok) begin
              if (hex_cnt_r >= 3'd4) begin
                feed_ok = 1'b0;
              end else begin
                hex_acc_nxt = {hex_acc_r[11:0], hexv.val};
                hex_cnt_nxt = hex_cnt_r + 3'd1;
              end
            end else if (in_ch == CH_COLON) begin
              if (hex_cnt_r == 3'd0) begin
                // Open the "::" gap at the current byte position.
                if (gap_seen_r) begin
                  feed_ok = 1'b0;
                end else begin
                  gap_seen_nxt = 1'b1;
                  gap_pos_nxt  = byte_cnt_r;
                end
              end else if (byte_cnt_r > ADDR_BYTES - 5'd2) begin
                feed_ok = 1'b0;
              end else begin
                sh_nxt        = {sh_r[111:0], hex_acc_r};
                byte_cnt_nxt  = byte_cnt_r + 5'd2;
                hex_acc_nxt   = '0;
                hex_cnt_nxt   = '0;
                colon_grp_nxt = 1'b1;
              end
            end else if (in_ch == CH_DOT) begin
              // Switch to the embedded dotted tail.
              if (byte_cnt_r > ADDR_BYTES - 5'd4) begin
                feed_ok = 1'b0;
              end else begin
                tail_nxt    = 1'b1;
                v4_nxt      = dot_step.st;
                feed_ok     = dot_step.ok;
                hex_acc_nxt = '0;
                hex_cnt_nxt = '0;
              end
            end else begin
              feed_ok = 1'b0;
            end
          end
          if (!feed_ok) err_nxt = 1'b1;
        end
      end
    end
  end

  // Terminator: close the last group or tail and expand the gap.
  always_comb begin
    fok  = (phase_r != PH_LEAD);
    sh_f = sh_r;
    bc_f = byte_cnt_r;
    if (tail_r) begin
      if (v4_r.cnt != 3'd4) fok = 1'b0;
      sh_f = {sh_r[95:0], v4_r.bytes};
      bc_f = byte_cnt_r + 5'd4;
    end else begin
      if (colon_grp_r) fok = 1'b0;
      if (hex_cnt_r != 3'd0) begin
        if (byte_cnt_r > ADDR_BYTES - 5'd2) fok = 1'b0;
        sh_f = {sh_r[111:0], hex_acc_r};
        bc_f = byte_cnt_r + 5'd2;
      end
    end

    gap_n   = bc_f - gap_pos_r;
    pre_n   = ADDR_BYTES - gap_pos_r;
    gap_res = (sh_f & ~(ALL_ONES << {gap_n[3:0], 3'b000}))
            | ((sh_f >> {gap_n[3:0], 3'b000}) << {pre_n, 3'b000});

    if (gap_seen_r) begin
      if (bc_f >= ADDR_BYTES || gap_pos_r > bc_f) fok = 1'b0;
    end else begin
      if (bc_f != ADDR_BYTES) fok = 1'b0;
    end

    fin_status = ST_MALFORMED;
    fin_addr   = '0;
    priority if (!fam_ok) begin
      fin_status = ST_UNSUPPORTED;
    end else if (err_r) begin
      fin_status = ST_MALFORMED;
    end else if (eff_fam == FAM_V4) begin
      if (v4_r.cnt == 3'd4) begin
        fin_status = ST_OK;
        fin_addr   = {96'd0, v4_r.bytes};
      end
    end else if (fok) begin
      fin_status = ST_OK;
      fin_addr   = gap_seen_r ? gap_res : sh_f;
    end else begin
      fin_status = ST_MALFORMED;
    end
  end

  // Hold a result until taken; load a new one on each terminator.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && is_term) out_valid_nxt = 1'b1;
    else if (out_ready)     out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      fam_r       <= '0;
      err_r       <= 1'b0;
      sh_r        <= '0;
      byte_cnt_r  <= '0;
      gap_pos_r   <= '0;
      gap_seen_r  <= 1'b0;
      hex_acc_r   <= '0;
      hex_cnt_r   <= '0;
      colon_grp_r <= 1'b0;
      tail_r      <= 1'b0;
      v4_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fam_r       <= fam_nxt;
      err_r       <= err_nxt;
      sh_r        <= sh_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      gap_pos_r   <= gap_pos_nxt;
      gap_seen_r  <= gap_seen_nxt;
      hex_acc_r   <= hex_acc_nxt;
      hex_cnt_r   <= hex_cnt_nxt;
      colon_grp_r <= colon_grp_nxt;
      tail_r      <= tail_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on the terminator only.
  always_ff @(posedge clk) begin
    if (in_fire && is_term) begin
      out_status_r    <= fin_status;
      out_addr_high_r <= fin_addr[127:64];
      out_addr_low_r  <= fin_addr[63:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_addr_high = out_addr_high_r;
  assign out_addr_low  = out_addr_low_r;

endmodule

// ----- bench/ip_address_text_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP address text parser testbench
// Streams address strings into the parser one character per item, predicts
// the status and 128-bit address of every string, and compares each result.
// ----------------------------------------------------------------------------
module ip_address_text_parser_test;
  import iptp_pkg::*;

  // Parse position within the current string.
  typedef enum int {
    AT_START,
    AFTER_COLON,
    IN_BODY
  } text_phase_t;

  typedef struct {
    status_t     status;
    logic [63:0] high;
    logic [63:0] low;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ch;
  logic [1:0]  in_family;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [63:0] out_addr_high;
  logic [63:0] out_addr_low;

  // Results predicted for accepted terminators, oldest first.
  parse_result_t pending_results[$];
  // Text of the string being built for the next send.
  logic [7:0]    addr_text[$];

  int error_count = 0;
  int chars_sent  = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left   = 0;

  // Predicted parser state.
  logic [7:0]  bin_bytes[16];
  int          bin_fill;
  int          gap_at;
  bit          gap_open;
  logic [15:0] group_val;
  bit          group_seen;
  int          group_digits;
  logic [7:0]  dec_val;
  bit          dec_seen;
  int          dec_count;
  logic [7:0]  dec_bytes[4];
  bit          in_tail;
  text_phase_t str_phase;
  bit          trailing_colon;
  bit          str_bad;
  logic [1:0]  str_family;

  ip_address_text_parser uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_ch         (in_ch),
    .in_family     (in_family),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_addr_high (out_addr_high),
    .out_addr_low  (out_addr_low)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Address predictor
  // --------------------------------------------------------------------------

  function automatic void clear_text_state();
    for (int i = 0; i < 16; i++) bin_bytes[i] = 8'd0;
    for (int i = 0; i < 4; i++) dec_bytes[i] = 8'd0;
    bin_fill       = 0;
    gap_at         = 0;
    gap_open       = 1'b0;
    group_val      = 16'd0;
    group_seen     = 1'b0;
    group_digits   = 0;
    dec_val        = 8'd0;
    dec_seen       = 1'b0;
    dec_count      = 0;
    in_tail        = 1'b0;
    str_phase      = AT_START;
    trailing_colon = 1'b0;
    str_bad        = 1'b0;
  endfunction

  // One dotted-decimal character; 0 means malformed.
  function automatic bit dec_char(int c);
    int n;
    if (c >= CH_0 && c <= CH_9) begin
      if (dec_seen && dec_val == 8'd0) return 1'b0;
      n = int'(dec_val) * 10 + c - int'(CH_0);
      if (n > 255) return 1'b0;
      dec_val = n[7:0];
      if (!dec_seen) begin
        if (dec_count >= 4) return 1'b0;
        dec_count++;
        dec_seen = 1'b1;
      end
      dec_bytes[(dec_count - 1) & 3] = dec_val;
      return 1'b1;
    end
    if (c == CH_DOT && dec_seen) begin
      if (dec_count == 4) return 1'b0;
      dec_seen = 1'b0;
      dec_val  = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void store_group();
    bin_bytes[bin_fill & 15]       = group_val[15:8];
    bin_bytes[(bin_fill + 1) & 15] = group_val[7:0];
    bin_fill += 2;
  endfunction

  // One colon-hex character; 0 means malformed.
  function automatic bit hex_char(int c);
    int         v;
    int         digits;
    logic [3:0] nib;
    v = -1;
    trailing_colon = 1'b0;
    if (in_tail) return dec_char(c);
    if (c >= CH_UA && c <= CH_UF) c += 32;
    if (c >= CH_0 && c <= CH_9) v = c - int'(CH_0);
    else if (c >= CH_LA && c <= CH_LF) v = c - int'(CH_LA) + 10;
    if (v >= 0) begin
      if (group_digits >= 4) return 1'b0;
      group_val = {group_val[11:0], v[3:0]};
      group_digits++;
      group_seen = 1'b1;
      return 1'b1;
    end
    if (c == CH_COLON) begin
      if (!group_seen) begin
        if (gap_open) return 1'b0;
        gap_open = 1'b1;
        gap_at   = bin_fill;
        return 1'b1;
      end
      if (bin_fill + 2 > 16) return 1'b0;
      store_group();
      group_val      = 16'd0;
      group_seen     = 1'b0;
      group_digits   = 0;
      trailing_colon = 1'b1;
      return 1'b1;
    end
    if (c == CH_DOT) begin
      digits = group_digits;
      if (bin_fill + 4 > 16) return 1'b0;
      in_tail   = 1'b1;
      dec_val   = 8'd0;
      dec_seen  = 1'b0;
      dec_count = 0;
      // Re-read the pending group as the first decimal octet.
      for (int k = 0; k < digits && k < 4; k++) begin
        nib = group_val[4 * (digits - 1 - k) +: 4];
        if (nib > 4'd9) return 1'b0;
        if (!dec_char(int'(CH_0) + nib)) return 1'b0;
      end
      group_val    = 16'd0;
      group_seen   = 1'b0;
      group_digits = 0;
      return dec_char(CH_DOT);
    end
    return 1'b0;
  endfunction

  // Close an IPv6 string: flush the last group or tail, expand the gap.
  function automatic bit close_v6();
    logic [7:0] spread[16];
    int         n;
    if (str_phase == AFTER_COLON) return 1'b0;
    if (in_tail) begin
      if (dec_count < 4) return 1'b0;
      for (int i = 0; i < 4; i++) bin_bytes[(bin_fill + i) & 15] = dec_bytes[i];
      bin_fill += 4;
    end else begin
      if (trailing_colon) return 1'b0;
      if (group_seen) begin
        if (bin_fill + 2 > 16) return 1'b0;
        store_group();
      end
    end
    if (gap_open) begin
      if (bin_fill >= 16 || gap_at > bin_fill) return 1'b0;
      n = bin_fill - gap_at;
      for (int i = 0; i < 16; i++) spread[i] = 8'd0;
      for (int i = 0; i < gap_at; i++) spread[i] = bin_bytes[i];
      for (int i = 0; i < n; i++) spread[16 - n + i] = bin_bytes[gap_at + i];
      bin_bytes = spread;
      bin_fill  = 16;
    end
    return bin_fill == 16;
  endfunction

  // Advance the prediction by one accepted character.
  function automatic void take_char(logic [7:0] c, logic [1:0] fam);
    parse_result_t r;
    bit            ok;
    if (str_phase == AT_START) begin
      str_family = fam;
      if (c != CH_NUL) begin
        str_phase = (fam == FAM_V6 && c == CH_COLON) ? AFTER_COLON : IN_BODY;
        if (str_phase == IN_BODY && str_family <= FAM_V6) begin
          ok = (str_family == FAM_V4) ? dec_char(c) : hex_char(c);
          if (!ok) str_bad = 1'b1;
        end
        return;
      end
    end
    if (c != CH_NUL) begin
      if (str_bad || str_family > FAM_V6) return;
      if (str_phase == AFTER_COLON) begin
        str_phase = IN_BODY;
        if (c != CH_COLON) begin
          str_bad = 1'b1;
          return;
        end
      end
      ok = (str_family == FAM_V4) ? dec_char(c) : hex_char(c);
      if (!ok) str_bad = 1'b1;
      return;
    end
    // Terminator: build the result and start over.
    r.status = ST_MALFORMED;
    r.high   = 64'd0;
    r.low    = 64'd0;
    if (str_family > FAM_V6) begin
      r.status = ST_UNSUPPORTED;
    end else if (!str_bad) begin
      if (str_family == FAM_V4) begin
        if (dec_count == 4) begin
          r.status = ST_OK;
          r.low    = {32'd0, dec_bytes[0], dec_bytes[1], dec_bytes[2], dec_bytes[3]};
        end
      end else if (close_v6()) begin
        r.status = ST_OK;
        for (int i = 0; i < 8; i++) r.high = {r.high[55:0], bin_bytes[i]};
        for (int i = 8; i < 16; i++) r.low = {r.low[55:0], bin_bytes[i]};
      end
    end
    pending_results.push_back(r);
    clear_text_state();
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d", out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_addr_high !== want.high)
          report_mismatch($sformatf("addr_high got %h want %h", out_addr_high, want.high));
        if (out_addr_low !== want.low)
          report_mismatch($sformatf("addr_low got %h want %h", out_addr_low, want.low));
      end
    end
  end

  // Result side: random stalls, or a long hold-off while hold_left counts down.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Send one character; called and returns at a falling edge.
  task automatic send_char(input logic [7:0] c, input logic [1:0] fam);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_ch     <= c;
    in_family <= fam;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    take_char(c, fam);
    chars_sent++;
    @(negedge clk);
  endtask

  // Send the built text plus terminator; only the first character's family counts,
  // so randomize the rest to show the block ignores them.
  task automatic send_text(input logic [1:0] fam);
    for (int i = 0; i < addr_text.size(); i++)
      send_char(addr_text[i], (i == 0) ? fam : 2'($urandom_range(3)));
    send_char(CH_NUL, (addr_text.size() == 0) ? fam : 2'($urandom_range(3)));
    addr_text.delete();
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
  endfunction

  task automatic send_line(input string s, input logic [1:0] fam);
    put_text(s);
    send_text(fam);
  endtask

  // Drop valid and hold the input until every predicted result is out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic void put_dotted();
    for (int i = 0; i < 4; i++) begin
      if (i > 0) addr_text.push_back(CH_DOT);
      put_text($sformatf("%0d", $urandom_range(255)));
    end
  endfunction

  function automatic void put_hex_group();
    int digits;
    int nib;
    bit upper;
    digits = $urandom_range(1, 4);
    upper  = $urandom_range(1);
    repeat (digits) begin
      nib = $urandom_range(15);
      if (nib < 10) addr_text.push_back(8'(int'(CH_0) + nib));
      else addr_text.push_back(8'(int'(upper ? CH_UA : CH_LA) + nib - 10));
    end
  endfunction

  // Well-formed IPv6 text: optional gap, optional dotted tail.
  function automatic void put_v6();
    bit tail;
    bit gap;
    int total;
    int present;
    int left;
    int right;
    tail    = ($urandom_range(3) == 0);
    gap     = $urandom_range(1);
    total   = tail ? 6 : 8;
    present = gap ? $urandom_range(total - 1) : total;
    left    = gap ? $urandom_range(present) : present;
    right   = present - left;
    for (int i = 0; i < left; i++) begin
      put_hex_group();
      if (i < left - 1 || (!gap && tail)) addr_text.push_back(CH_COLON);
    end
    if (gap) begin
      addr_text.push_back(CH_COLON);
      addr_text.push_back(CH_COLON);
    end
    for (int i = 0; i < right; i++) begin
      put_hex_group();
      if (i < right - 1 || tail) addr_text.push_back(CH_COLON);
    end
    if (tail) put_dotted();
  endfunction

  // Break the text: overwrite, insert, or chop off the end.
  function automatic void mangle_text();
    string      picks;
    logic [7:0] pick;
    int         op;
    int         pos;
    picks = ":.0159afAFg/ ";
    op    = $urandom_range(2);
    if (addr_text.size() == 0) op = 1;
    pos  = (addr_text.size() > 0) ? $urandom_range(addr_text.size() - 1) : 0;
    pick = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                    : picks[$urandom_range(picks.len() - 1)];
    case (op)
      0: addr_text[pos] = pick;
      1: addr_text.insert(pos, pick);
      default: begin
        repeat ($urandom_range(1, 3))
          if (addr_text.size() > 0) void'(addr_text.pop_back());
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Dotted decimal: extremes, range and leading-zero rules, octet count.
  task automatic test_ipv4_forms();
    send_line("0.0.0.0", FAM_V4);
    send_line("255.255.255.255", FAM_V4);
    send_line("256.1.1.1", FAM_V4);
    send_line("01.2.3.4", FAM_V4);
    send_line("1.2.3", FAM_V4);
    send_line("1.2.3.4.5", FAM_V4);
    send_line("", FAM_V4);
  endtask

  // Colon hex: gap forms, case, long group, leading and trailing colon, second gap.
  task automatic test_ipv6_forms();
    send_line("::", FAM_V6);
    send_line("fe80::", FAM_V6);
    send_line("FFFF:abcd:0:0:0:0:0:1", FAM_V6);
    send_line("12345::", FAM_V6);
    send_line(":1::", FAM_V6);
    send_line("1:2:", FAM_V6);
    send_line("1::2::3", FAM_V6);
    send_line("1:2:3:4:5:6:7:8::", FAM_V6);
    send_line("", FAM_V6);
  endtask

  // Embedded IPv4 tail: good, no room, hex in first token, colon after it.
  task automatic test_dotted_tail();
    send_line("::ffff:1.2.3.4", FAM_V6);
    send_line("1:2:3:4:5:6:7:1.2.3.4", FAM_V6);
    send_line("::1a.2.3.4", FAM_V6);
    send_line("::1.2.3.4:5", FAM_V6);
  endtask

  // Unsupported families and bytes outside ASCII.
  task automatic test_odd_inputs();
    send_line("1.2.3.4", 2'd2);
    send_line("", 2'd3);
    put_text("1.2.3.");
    addr_text.push_back(8'hff);
    send_text(FAM_V4);
    put_text("::");
    addr_text.push_back(8'h80);
    send_text(FAM_V6);
  endtask

  // Hold the result side off long enough to stall the input, then drain.
  task automatic test_backpressure();
    int save_send;
    save_send     = send_idle_pct;
    send_idle_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    repeat (12) begin
      put_dotted();
      send_text(FAM_V4);
    end
    // Pause the input until every result is out.
    wait_drained();
    send_idle_pct = save_send;
  endtask

  // Mostly well-formed strings with random content, the rest broken or noise.
  task automatic test_random_mix(input int send_pct, input int recv_pct, input int n_chars);
    int stop_at;
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at       = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        put_dotted();
        send_text(FAM_V4);
      end else if (pick < 70) begin
        put_v6();
        send_text(FAM_V6);
      end else if (pick < 85) begin
        if (pick < 78) put_dotted();
        else put_v6();
        repeat ($urandom_range(1, 2)) mangle_text();
        send_text((pick < 78) ? FAM_V4 : FAM_V6);
      end else if (pick < 95) begin
        repeat ($urandom_range(8)) addr_text.push_back(8'($urandom_range(1, 255)));
        send_text(2'($urandom_range(3)));
      end else begin
        put_v6();
        send_text(2'($urandom_range(3)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int waited;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_ch     = CH_NUL;
    in_family = FAM_V4;
    clear_text_state();
    str_family = FAM_V4;
    // Sender idles a little, receiver a lot, during the directed part.
    send_idle_pct = 12;
    recv_idle_pct = 71;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_ipv4_forms();
    test_ipv6_forms();
    test_dotted_tail();
    test_odd_inputs();
    test_backpressure();
    test_random_mix(12, 71, 270);
    test_random_mix(71, 12, 270);
    test_random_mix(0, 0, 270);

    // Drop valid and let the last results drain, with a bound.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (error_count == 0) begin
      $display("ip_address_text_parser_test: PASS");
    end else begin
      $display("ip_address_text_parser_test: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("ip_address_text_parser_test: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/iptp_pkg.sv
hdl/ip_address_text_parser.sv
bench/ip_address_text_parser_test.sv
